// File: src/scfb_pkg.sv
// ----------------------------------------------------------------------------
// scfb_pkg
// Shared types, codes and helpers of the screen command frame builder.
// ----------------------------------------------------------------------------
package scfb_pkg;

	localparam int KIND_W  = 2;
	localparam int VALUE_W = 16;
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 3;

	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PARAM = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

	localparam logic [1:0] OP_CMD1  = 2'd0;
	localparam logic [1:0] OP_CMD2  = 2'd1;
	localparam logic [1:0] OP_PARAM = 2'd2;
	localparam logic [1:0] OP_CLOSE = 2'd3;

	localparam logic [VALUE_W-1:0] TWO_BYTE_MASK = 16'hFF00;
	localparam logic [VALUE_W-1:0] TWO_BYTE_CODE = 16'hB100;
	localparam logic [VALUE_W-1:0] STOP_PARAM    = 16'hFFFF;
	localparam logic [VALUE_W-1:0] CRC_INIT      = 16'hFFFF;
	localparam logic [VALUE_W-1:0] CRC_POLY      = 16'hA001;

	localparam logic [BYTE_W-1:0] HEAD_BYTE  = 8'hEE;
	localparam logic [BYTE_W-1:0] TAIL_FF    = 8'hFF;
	localparam logic [BYTE_W-1:0] TAIL_FC    = 8'hFC;

	localparam logic [IDX_W-1:0] IDX_CRC_HI = 3'd0;
	localparam logic [IDX_W-1:0] IDX_CRC_LO = 3'd1;
	localparam logic [IDX_W-1:0] IDX_TAIL_1 = 3'd3;
	localparam logic [IDX_W-1:0] IDX_TAIL_3 = 3'd5;

	typedef struct packed {
		logic [1:0]         op;
		logic [VALUE_W-1:0] value;
	} scfb_op_t;

	function automatic logic [VALUE_W-1:0] crc_byte(input logic [VALUE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [VALUE_W-1:0] c;
		c = crc ^ {{(VALUE_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [IDX_W-1:0] op_last_idx(input logic [1:0] op);
		logic [IDX_W-1:0] r;
		unique case (op)
			OP_CMD1:  r = 3'd1;
			OP_CMD2:  r = 3'd2;
			OP_PARAM: r = 3'd1;
			OP_CLOSE: r = 3'd5;
			default:  r = 3'd0;
		endcase
		return r;
	endfunction

endpackage

// File: src/scfb_in_if.sv
// ----------------------------------------------------------------------------
// scfb_in_if
// Item channel: kind and value with valid/ready.
// ----------------------------------------------------------------------------
interface scfb_in_if;
	import scfb_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [VALUE_W-1:0] value;

	modport source(output valid, output kind, output value, input ready);
	modport sink(input valid, input kind, input value, output ready);
endinterface

// File: src/scfb_out_if.sv
// ----------------------------------------------------------------------------
// scfb_out_if
// Byte channel: frame byte and last flag with valid/ready.
// ----------------------------------------------------------------------------
interface scfb_out_if;
	import scfb_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source(output valid, output out_byte, output last, input ready);
	modport sink(input valid, input out_byte, input last, output ready);
endinterface

// File: src/scfb_front.sv
// ----------------------------------------------------------------------------
// scfb_front
// Accepts items, tracks the open frame and classifies items into byte jobs.
// ----------------------------------------------------------------------------
module scfb_front (
	input  logic              clk,
	input  logic              arst_n,
	scfb_in_if.sink           cmd_in,
	input  logic              q_full,
	output logic              q_push,
	output scfb_pkg::scfb_op_t q_entry
);
	import scfb_pkg::*;

	logic frame_open_q;
	logic take;
	logic emit;
	logic open_nx;

	assign cmd_in.ready = !q_full;
	assign take = cmd_in.valid && cmd_in.ready;

	always_comb begin
		emit          = 1'b0;
		open_nx       = frame_open_q;
		q_entry.value = cmd_in.value;
		q_entry.op    = OP_PARAM;
		priority if (cmd_in.kind == KIND_CMD) begin
			emit    = 1'b1;
			open_nx = 1'b1;
			q_entry.op = ((cmd_in.value & TWO_BYTE_MASK) == TWO_BYTE_CODE) ? OP_CMD2 : OP_CMD1;
		end else if (frame_open_q && cmd_in.kind == KIND_PARAM) begin
			emit = 1'b1;
			if (cmd_in.value == STOP_PARAM) begin
				q_entry.op = OP_CLOSE;
				open_nx    = 1'b0;
			end
		end else if (frame_open_q && cmd_in.kind == KIND_END) begin
			emit       = 1'b1;
			q_entry.op = OP_CLOSE;
			open_nx    = 1'b0;
		end else begin
			emit = 1'b0;
		end
	end

	assign q_push = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
		end else if (take) begin
			frame_open_q <= open_nx;
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("push into full queue");
	a_cmd_opens: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd_in.kind == KIND_CMD |=> frame_open_q) else $error("command left frame closed");
	a_close_shuts: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && q_entry.op == OP_CLOSE |=> !frame_open_q) else $error("close left frame open");
endmodule

// File: src/scfb_queue.sv
// ----------------------------------------------------------------------------
// scfb_queue
// Short FIFO of byte jobs between the front and the back.
// ----------------------------------------------------------------------------
module scfb_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  scfb_pkg::scfb_op_t push_entry,
	input  logic               pop,
	output logic               full,
	output logic               head_valid,
	output scfb_pkg::scfb_op_t head
);
	import scfb_pkg::*;

	scfb_op_t            mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                do_pop;

	assign full       = cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q - rd_ptr_q == cnt_q[QUEUE_AW-1:0]) else $error("queue pointers out of step");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count lost push");
endmodule

// File: src/scfb_back.sv
// ----------------------------------------------------------------------------
// scfb_back
// Byte sequencer: walks each job byte by byte, keeps the CRC, drives output.
// ----------------------------------------------------------------------------
module scfb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  scfb_pkg::scfb_op_t head,
	output logic               pop,
	scfb_out_if.source         frame_out
);
	import scfb_pkg::*;

	logic                busy_q;
	scfb_op_t            job_q;
	logic [IDX_W-1:0]    idx_q;
	logic [VALUE_W-1:0]  crc_q;
	logic                ov_q;
	logic [BYTE_W-1:0]   ob_q;
	logic                ol_q;

	logic                advance;
	logic                at_end;
	logic [BYTE_W-1:0]   cur_byte;
	logic                cur_body;
	logic                cur_fresh;
	logic                cur_last;
	logic [VALUE_W-1:0]  crc_base;

	assign advance = busy_q && (!ov_q || frame_out.ready);
	assign at_end  = idx_q == op_last_idx(job_q.op);
	assign pop     = !busy_q || (advance && at_end);

	always_comb begin
		cur_byte  = HEAD_BYTE;
		cur_body  = 1'b0;
		cur_fresh = 1'b0;
		cur_last  = 1'b0;
		unique case (job_q.op)
			OP_CMD1, OP_CMD2: begin
				if (idx_q == '0) begin
					cur_fresh = 1'b1;
				end else begin
					cur_body = 1'b1;
					cur_byte = (job_q.op == OP_CMD2 && idx_q == 3'd1) ?
						job_q.value[VALUE_W-1:BYTE_W] : job_q.value[BYTE_W-1:0];
				end
			end
			OP_PARAM: begin
				cur_body = 1'b1;
				cur_byte = (idx_q == '0) ? job_q.value[VALUE_W-1:BYTE_W] : job_q.value[BYTE_W-1:0];
			end
			OP_CLOSE: begin
				priority if (idx_q == IDX_CRC_HI) begin
					cur_byte = crc_q[VALUE_W-1:BYTE_W];
				end else if (idx_q == IDX_CRC_LO) begin
					cur_byte = crc_q[BYTE_W-1:0];
				end else if (idx_q == IDX_TAIL_1) begin
					cur_byte = TAIL_FC;
				end else begin
					cur_byte = TAIL_FF;
				end
				cur_last = idx_q == IDX_TAIL_3;
			end
			default: cur_byte = HEAD_BYTE;
		endcase
	end

	assign crc_base = crc_q;

	always_ff @(posedge clk) begin
		if (pop && head_valid) begin
			job_q <= head;
		end
		if (advance) begin
			ob_q <= cur_byte;
			ol_q <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			crc_q  <= CRC_INIT;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= head_valid;
				idx_q  <= '0;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (advance) begin
				priority if (cur_fresh || cur_last) begin
					crc_q <= CRC_INIT;
				end else if (cur_body) begin
					crc_q <= crc_byte(crc_base, cur_byte);
				end
			end
			if (advance) begin
				ov_q <= 1'b1;
			end else if (frame_out.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign frame_out.valid    = ov_q;
	assign frame_out.out_byte = ob_q;
	assign frame_out.last     = ol_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= op_last_idx(job_q.op)) else $error("byte index past job end");
	a_crc_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cur_last |=> crc_q == CRC_INIT) else $error("crc not reset after tail");
	a_load_job: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q && head_valid |=> busy_q && idx_q == '0) else $error("waiting job not loaded");
endmodule

// File: src/screen_command_frame_builder.sv
// ----------------------------------------------------------------------------
// screen_command_frame_builder
// Turns command, parameter and end items into display command frames.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle while the four-entry job queue has
// room; items of kind three or with no frame open are dropped. The back end
// sends one byte per cycle unless stalled: a parameter is 2 bytes, a command
// 2 (single byte) or 3 (two-byte code), a close 6 (CRC high, CRC low, tail FF
// FC FF FF). The byte sequencer sets the sustained rate; the output register
// lets the next byte be prepared while the current one waits for transfer.
// ----------------------------------------------------------------------------
module screen_command_frame_builder (
	input  logic       clk,
	input  logic       arst_n,
	scfb_in_if.sink    cmd_in,
	scfb_out_if.source frame_out
);
	import scfb_pkg::*;

	logic     q_full;
	logic     q_push;
	scfb_op_t q_entry;
	logic     q_pop;
	logic     q_head_valid;
	scfb_op_t q_head;

	scfb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (cmd_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_entry)
	);

	scfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	scfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.frame_out  (frame_out)
	);
endmodule

// File: tb/sv/screen_command_frame_builder_test.sv
// ----------------------------------------------------------------------------
// screen_command_frame_builder_test
// Self-checking bench for the display command frame builder.
// ----------------------------------------------------------------------------
// A short table of command, parameter and end items exercises the field
// extremes and the corner cases. These include items with no open frame,
// kind three, an abandoned frame, two-byte and single-byte codes, and the
// stop parameter. After the table come random frames with some noise mixed
// in. Every transfer into the block runs through a bit-level frame predictor
// that tracks the running CRC. Every byte leaving the block is compared
// against the oldest predicted byte. The sender idles and the receiver
// stalls at several rates. One long receiver hold-off fills the job queue.
// ----------------------------------------------------------------------------
module screen_command_frame_builder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import scfb_pkg::*;

	localparam logic [KIND_W-1:0] KIND_VOID = 2'd3;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_ITEMS    = 88;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} wire_byte_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               fixed;
		logic [1:0]         n_fixed;
		logic [23:0]        fixed_bytes;
	} stim_row_t;

	logic clk;
	logic arst_n;

	scfb_in_if  cmd_if();
	scfb_out_if frame_if();

	screen_command_frame_builder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd_if),
		.frame_out (frame_if)
	);

	stim_row_t directed_rows [23] = '{
		'{KIND_PARAM, 16'h1234, 1'b1, 2'd0, 24'h000000},
		'{KIND_END,   16'h0000, 1'b1, 2'd0, 24'h000000},
		'{KIND_VOID,  16'hFFFF, 1'b1, 2'd0, 24'h000000},
		'{KIND_CMD,   16'h0000, 1'b1, 2'd2, 24'hEE0000},
		'{KIND_PARAM, 16'h0000, 1'b1, 2'd2, 24'h000000},
		'{KIND_PARAM, 16'hFFFE, 1'b1, 2'd2, 24'hFFFE00},
		'{KIND_END,   16'h0000, 1'b0, 2'd0, 24'h000000},
		'{KIND_CMD,   16'hB1FF, 1'b1, 2'd3, 24'hEEB1FF},
		'{KIND_PARAM, 16'hFFFF, 1'b0, 2'd0, 24'h000000},
		'{KIND_PARAM, 16'h5555, 1'b1, 2'd0, 24'h000000},
		'{KIND_CMD,   16'hFFFF, 1'b1, 2'd2, 24'hEEFF00},
		'{KIND_CMD,   16'hB100, 1'b1, 2'd3, 24'hEEB100},
		'{KIND_VOID,  16'h0000, 1'b1, 2'd0, 24'h000000},
		'{KIND_PARAM, 16'hAAAA, 1'b1, 2'd2, 24'hAAAA00},
		'{KIND_END,   16'hFFFF, 1'b0, 2'd0, 24'h000000},
		'{KIND_END,   16'h0000, 1'b1, 2'd0, 24'h000000},
		'{KIND_CMD,   16'hB0FF, 1'b1, 2'd2, 24'hEEFF00},
		'{KIND_CMD,   16'hB200, 1'b1, 2'd2, 24'hEE0000},
		'{KIND_PARAM, 16'h8001, 1'b1, 2'd2, 24'h800100},
		'{KIND_PARAM, 16'h7FFE, 1'b1, 2'd2, 24'h7FFE00},
		'{KIND_PARAM, 16'hFFFF, 1'b0, 2'd0, 24'h000000},
		'{KIND_CMD,   16'h00A5, 1'b1, 2'd2, 24'hEEA500},
		'{KIND_END,   16'h0000, 1'b0, 2'd0, 24'h000000}
	};

	logic [VALUE_W-1:0] crc_run;
	logic               frame_live;
	wire_byte_t         item_bytes [$];
	wire_byte_t         frame_q [$];
	wire_byte_t         next_byte;

	int err_count;
	int live_items;
	int idle_pct;
	int stall_pct;
	int hold_requests;
	int quiet_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic log_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic logic [VALUE_W-1:0] rand16();
		logic [31:0] r;
		r = $urandom();
		return r[VALUE_W-1:0];
	endfunction

	function automatic stim_row_t plain_row(input logic [KIND_W-1:0] kind,
		input logic [VALUE_W-1:0] value);
		return '{kind, value, 1'b0, 2'd0, 24'h000000};
	endfunction

	function automatic void put_byte(input logic [BYTE_W-1:0] b, input logic last,
		input logic in_crc);
		logic fb;
		item_bytes.push_back('{b, last});
		if (in_crc) begin
			for (int i = 0; i < BYTE_W; i++) begin
				fb = crc_run[0] ^ b[i];
				crc_run = crc_run >> 1;
				if (fb) begin
					crc_run = crc_run ^ CRC_POLY;
				end
			end
		end
	endfunction

	function automatic int frame_step(input logic [KIND_W-1:0] kind,
		input logic [VALUE_W-1:0] value);
		item_bytes.delete();
		if (kind == KIND_CMD) begin
			crc_run = CRC_INIT;
			frame_live = 1'b1;
			put_byte(HEAD_BYTE, 1'b0, 1'b0);
			if ((value & TWO_BYTE_MASK) == TWO_BYTE_CODE) begin
				put_byte(value[15:8], 1'b0, 1'b1);
			end
			put_byte(value[7:0], 1'b0, 1'b1);
		end else if (frame_live && (kind == KIND_END ||
			(kind == KIND_PARAM && value == STOP_PARAM))) begin
			put_byte(crc_run[15:8], 1'b0, 1'b0);
			put_byte(crc_run[7:0], 1'b0, 1'b0);
			put_byte(TAIL_FF, 1'b0, 1'b0);
			put_byte(TAIL_FC, 1'b0, 1'b0);
			put_byte(TAIL_FF, 1'b0, 1'b0);
			put_byte(TAIL_FF, 1'b1, 1'b0);
			crc_run = CRC_INIT;
			frame_live = 1'b0;
		end else if (frame_live && kind == KIND_PARAM) begin
			put_byte(value[15:8], 1'b0, 1'b1);
			put_byte(value[7:0], 1'b0, 1'b1);
		end
		return item_bytes.size();
	endfunction

	// call at a falling edge; returns at a falling edge
	task automatic offer(input stim_row_t row);
		int n;
		logic [31:0] junk;
		while ($urandom_range(99) < idle_pct) begin
			junk = $urandom();
			cmd_if.valid <= 1'b0;
			cmd_if.kind  <= junk[KIND_W-1:0];
			cmd_if.value <= junk[31:16];
			@(negedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.kind  <= row.kind;
		cmd_if.value <= row.value;
		do @(posedge clk); while (!cmd_if.ready);
		n = frame_step(row.kind, row.value);
		if (row.fixed) begin
			for (int i = 0; i < row.n_fixed; i++) begin
				frame_q.push_back('{row.fixed_bytes[23 - 8*i -: 8], 1'b0});
			end
		end else begin
			foreach (item_bytes[i]) begin
				frame_q.push_back(item_bytes[i]);
			end
		end
		if (n > 0) begin
			live_items++;
		end
		@(negedge clk);
	endtask

	task automatic drain();
		cmd_if.valid <= 1'b0;
		while (frame_q.size() != 0) begin
			@(negedge clk);
		end
		@(negedge clk);
	endtask

	task automatic random_frames(input int quota);
		int stop_at;
		int pick;
		logic [31:0] r;
		logic [VALUE_W-1:0] v;
		stop_at = live_items + quota;
		while (live_items < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				r = $urandom();
				offer(plain_row(r[KIND_W-1:0], r[31:16]));
			end else begin
				v = rand16();
				if ($urandom_range(2) == 0) begin
					v[15:8] = TWO_BYTE_CODE[15:8];
				end
				offer(plain_row(KIND_CMD, v));
				repeat ($urandom_range(4)) begin
					v = ($urandom_range(29) == 0) ? STOP_PARAM : rand16();
					offer(plain_row(KIND_PARAM, v));
				end
				pick = $urandom_range(9);
				if (pick < 7) begin
					offer(plain_row(KIND_END, rand16()));
				end else if (pick < 9) begin
					offer(plain_row(KIND_PARAM, STOP_PARAM));
				end
			end
		end
	endtask

	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		frame_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				frame_if.ready <= 1'b0;
				hold_left--;
			end else begin
				frame_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && frame_if.valid && frame_if.ready) begin
			if (frame_q.size() == 0) begin
				log_error($sformatf("byte %h last %b with nothing expected",
					frame_if.out_byte, frame_if.last));
			end else begin
				next_byte = frame_q.pop_front();
				if (frame_if.out_byte !== next_byte.data) begin
					log_error($sformatf("out_byte %h, expected %h",
						frame_if.out_byte, next_byte.data));
				end
				if (frame_if.last !== next_byte.last) begin
					log_error($sformatf("last %b on byte %h, expected %b",
						frame_if.last, frame_if.out_byte, next_byte.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_if.valid && cmd_if.ready) ||
			(frame_if.valid && frame_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		cmd_if.valid  = 1'b0;
		cmd_if.kind   = KIND_CMD;
		cmd_if.value  = '0;
		crc_run       = CRC_INIT;
		frame_live    = 1'b0;
		err_count     = 0;
		live_items    = 0;
		idle_pct      = 0;
		stall_pct     = 0;
		hold_requests = 0;
		quiet_cycles  = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			offer(directed_rows[i]);
		end
		drain();

		// hold the receiver off so the job queue fills and stalls the input
		hold_requests++;
		random_frames(PHASE_ITEMS);
		drain();

		idle_pct = 61;
		random_frames(PHASE_ITEMS);
		drain();

		idle_pct  = 0;
		stall_pct = 61;
		random_frames(PHASE_ITEMS);
		drain();

		idle_pct  = 25;
		stall_pct = 25;
		random_frames(PHASE_ITEMS);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
